/* src/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

/* src/huk_pkg.sv */
// ============================================================================
// huk_pkg
// Types, constants and the microprogram of the heap update-key engine.
// ============================================================================
package huk_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = 6;
    localparam int USED_W = 7;
    localparam int KEY_W  = 32;
    localparam int APB_W  = 32;
    localparam int STEP_W = 4;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        index;
        logic signed [KEY_W-1:0] value;
    } huk_req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] read_value;
        logic                    status;
    } huk_rsp_t;

    // Program steps.
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] ST_WR       = 4'd2;
    localparam logic [STEP_W-1:0] ST_RD       = 4'd3;
    localparam logic [STEP_W-1:0] ST_UP_TEST  = 4'd4;
    localparam logic [STEP_W-1:0] ST_UP_CMP   = 4'd5;
    localparam logic [STEP_W-1:0] ST_DN_L     = 4'd6;
    localparam logic [STEP_W-1:0] ST_DN_R     = 4'd7;
    localparam logic [STEP_W-1:0] ST_DN_CMP   = 4'd8;
    localparam logic [STEP_W-1:0] ST_PLACE    = 4'd9;
    localparam logic [STEP_W-1:0] ST_FIN      = 4'd10;

    typedef enum logic [1:0] {RA_IN, RA_PARENT, RA_LEFT, RA_RIGHT} rd_sel_t;
    typedef enum logic [1:0] {WD_VAL, WD_PARENT, WD_WIN} wr_sel_t;
    typedef enum logic [1:0] {PS_HOLD, PS_PARENT, PS_WIN} pos_sel_t;
    typedef enum logic [2:0] {
        C_ALWAYS, C_NO_REQ, C_DISPATCH, C_POS_ROOT,
        C_NOT_GT, C_LEFT_OUT, C_NO_WIN, C_OUT_BUSY
    } cond_t;

    // One control word per step. When gated is set, the datapath actions of
    // the word take effect only if the jump condition is false.
    typedef struct packed {
        logic              rd_en;
        rd_sel_t           rd_sel;
        logic              wr_en;
        wr_sel_t           wr_sel;
        pos_sel_t          pos_sel;
        logic              latch_in;
        logic              latch_rd;
        logic              latch_best;
        logic              load_out;
        logic              gated;
        cond_t             cond;
        logic [STEP_W-1:0] jt;
        logic [STEP_W-1:0] jf;
    } ctrl_word_t;

    typedef struct packed {
        ctrl_word_t word;
        logic       en;
    } huk_cmd_t;

    typedef struct packed {
        logic       req_valid;
        logic       bad;
        logic [1:0] op;
        logic       val_gt_rd;
        logic       pos_root;
        logic       left_out;
        logic       no_win;
        logic       out_busy;
    } huk_flags_t;

    function automatic ctrl_word_t microcode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w         = '0;
        w.rd_sel  = RA_IN;
        w.wr_sel  = WD_VAL;
        w.pos_sel = PS_HOLD;
        w.cond    = C_ALWAYS;
        w.jt      = ST_IDLE;
        w.jf      = ST_IDLE;
        unique case (step)
            ST_IDLE:
            begin
                w.rd_en    = 1'b1;
                w.rd_sel   = RA_IN;
                w.latch_in = 1'b1;
                w.gated    = 1'b1;
                w.cond     = C_NO_REQ;
                w.jt       = ST_IDLE;
                w.jf       = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                w.cond = C_DISPATCH;
            end
            ST_WR:
            begin
                w.wr_en  = 1'b1;
                w.wr_sel = WD_VAL;
                w.jt     = ST_FIN;
            end
            ST_RD:
            begin
                w.latch_rd = 1'b1;
                w.jt       = ST_FIN;
            end
            ST_UP_TEST:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RA_PARENT;
                w.gated  = 1'b1;
                w.cond   = C_POS_ROOT;
                w.jt     = ST_PLACE;
                w.jf     = ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                w.wr_en   = 1'b1;
                w.wr_sel  = WD_PARENT;
                w.pos_sel = PS_PARENT;
                w.gated   = 1'b1;
                w.cond    = C_NOT_GT;
                w.jt      = ST_PLACE;
                w.jf      = ST_UP_TEST;
            end
            ST_DN_L:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RA_LEFT;
                w.gated  = 1'b1;
                w.cond   = C_LEFT_OUT;
                w.jt     = ST_PLACE;
                w.jf     = ST_DN_R;
            end
            ST_DN_R:
            begin
                w.rd_en      = 1'b1;
                w.rd_sel     = RA_RIGHT;
                w.latch_best = 1'b1;
                w.jt         = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                w.wr_en   = 1'b1;
                w.wr_sel  = WD_WIN;
                w.pos_sel = PS_WIN;
                w.gated   = 1'b1;
                w.cond    = C_NO_WIN;
                w.jt      = ST_PLACE;
                w.jf      = ST_DN_L;
            end
            ST_PLACE:
            begin
                w.wr_en  = 1'b1;
                w.wr_sel = WD_VAL;
                w.jt     = ST_FIN;
            end
            ST_FIN:
            begin
                w.load_out = 1'b1;
                w.gated    = 1'b1;
                w.cond     = C_OUT_BUSY;
                w.jt       = ST_FIN;
                w.jf       = ST_IDLE;
            end
            default:
            begin
                w.jt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // Multiway jump taken right after a request has been latched.
    function automatic logic [STEP_W-1:0] dispatch_target(input logic bad,
                                                         input logic [1:0] op,
                                                         input logic up);
        logic [STEP_W-1:0] t;
        t = ST_FIN;
        if (!bad)
        begin
            unique case (op)
                OP_WRITE:  t = ST_WR;
                OP_READ:   t = ST_RD;
                OP_UPDATE: t = up ? ST_UP_TEST : ST_DN_L;
                default:   t = ST_FIN;
            endcase
        end
        return t;
    endfunction

endpackage

/* src/heap_update_key.sv */
// ============================================================================
// heap_update_key
// Binary max-heap of signed 32-bit keys with write, read and update-key.
//
// The block keeps up to 64 signed keys in an internal store and treats the
// first heap_size of them as a binary max-heap (children of entry i are
// 2i+1 and 2i+2). Each request carries an op, an index and a value, and
// produces exactly one response. A write stores the value at the index, a
// read returns the entry at the index, and an update replaces the key at the
// index and restores heap order: a larger key sifts up toward the root, any
// other key sifts down, swapping with the larger child (the left one on a
// tie). A request whose index is not below the used size returns status 1
// with a zero value and changes nothing. Only one request is in flight at a
// time; the next one is taken as soon as the engine is back at its idle step,
// even while the previous response is still waiting in the output register.
// An update swaps at most six times. The store gives one read and one write
// per cycle, so every heap level costs two steps of the microprogram going
// up and three going down. If the previous response is still stalled in the
// output register when a new one is ready, the engine holds at its last step
// until that response is taken. heap_size is the only register, at APB
// address 0; values above 64 are treated as 64. Entries must be written
// before they are read or compared; the store has no reset.
// ============================================================================
`include "assert_macros.svh"

module heap_update_key (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  huk_pkg::huk_req_t             req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output huk_pkg::huk_rsp_t             rsp_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [huk_pkg::APB_W-1:0]     pwdata,
    output logic [huk_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);
    import huk_pkg::*;

    logic [USED_W-1:0] heap_size_reg;
    logic [USED_W-1:0] used;
    huk_cmd_t          cmd;
    huk_flags_t        flags;
    logic              idle;

    // The register file holds only heap_size; address bit 2 selects beyond it,
    // and such writes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            heap_size_reg <= pwdata[USED_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : {{(APB_W - USED_W){1'b0}}, heap_size_reg};

    // The used size saturates at the store depth.
    assign used = (heap_size_reg > USED_W'(DEPTH)) ? USED_W'(DEPTH) : heap_size_reg;

    // A new request is taken only while the program sits at its idle step.
    assign req_stall = !idle;

    huk_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cmd   (cmd),
        .idle  (idle)
    );

    huk_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_valid (req_valid),
        .req_data  (req_data),
        .used      (used),
        .rsp_stall (rsp_stall),
        .flags     (flags),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

    `ASSERT_RST(a_one_in_flight, clk, rst_n, ((req_valid && !req_stall) |=> req_stall), "second request taken while busy")
    `ASSERT_RST(a_no_overwrite, clk, rst_n, ((cmd.en && cmd.word.load_out) |-> !(rsp_valid && rsp_stall)), "pending response overwritten")

endmodule

/* src/huk_sequencer.sv */
// ============================================================================
// huk_sequencer
// Step counter with the microprogram ROM and conditional jump logic.
// ============================================================================
`include "assert_macros.svh"

module huk_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  huk_pkg::huk_flags_t flags,
    output huk_pkg::huk_cmd_t   cmd,
    output logic                idle
);
    import huk_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_word_t        word;
    logic              cond_true;

    assign word = microcode(step_reg);

    always_comb
    begin
        unique case (word.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_NO_REQ:   cond_true = !flags.req_valid;
            C_DISPATCH: cond_true = 1'b0;
            C_POS_ROOT: cond_true = flags.pos_root;
            C_NOT_GT:   cond_true = !flags.val_gt_rd;
            C_LEFT_OUT: cond_true = flags.left_out;
            C_NO_WIN:   cond_true = flags.no_win;
            C_OUT_BUSY: cond_true = flags.out_busy;
            default:    cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        if (word.cond == C_DISPATCH)
        begin
            step_next = dispatch_target(flags.bad, flags.op, flags.val_gt_rd);
        end
        else if (cond_true)
        begin
            step_next = word.jt;
        end
        else
        begin
            step_next = word.jf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign cmd.word = word;
    assign cmd.en   = !(word.gated && cond_true);
    assign idle     = (step_reg == ST_IDLE);

    `ASSERT_CLK(a_step_in_program, clk, (!rst_n || step_reg <= ST_FIN), "step left program")

endmodule

/* src/huk_datapath.sv */
// ============================================================================
// huk_datapath
// Heap store, sift registers, comparators and the result register.
// ============================================================================
`include "assert_macros.svh"

module huk_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  huk_pkg::huk_cmd_t                 cmd,
    input  logic                              req_valid,
    input  huk_pkg::huk_req_t                 req_data,
    input  logic [huk_pkg::USED_W-1:0]        used,
    input  logic                              rsp_stall,
    output huk_pkg::huk_flags_t               flags,
    output logic                              rsp_valid,
    output huk_pkg::huk_rsp_t                 rsp_data
);
    import huk_pkg::*;

    logic [KEY_W-1:0]        mem [DEPTH];
    logic signed [KEY_W-1:0] rdata_reg;

    logic [1:0]              op_reg;
    logic [IDX_W-1:0]        pos_reg;
    logic signed [KEY_W-1:0] val_reg;
    logic                    bad_reg;
    logic signed [KEY_W-1:0] rd_reg;
    logic signed [KEY_W-1:0] best_key_reg;
    logic                    best_win_reg;
    logic                    out_valid_reg;
    huk_rsp_t                out_data_reg;

    logic                    act;
    logic [IDX_W-1:0]        parent;
    logic [USED_W-1:0]       left;
    logic [USED_W:0]         right;
    logic                    right_in;
    logic                    right_gt;
    logic [IDX_W-1:0]        win_idx;
    logic signed [KEY_W-1:0] win_key;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic                    best_gt;

    assign act      = cmd.en;
    assign parent   = (pos_reg - IDX_W'(1)) >> 1;
    assign left     = {pos_reg, 1'b1};
    assign right    = {1'b0, left} + (USED_W + 1)'(1);
    assign right_in = right < {1'b0, used};
    assign right_gt = right_in && (rdata_reg > best_key_reg);
    assign win_idx  = right_gt ? right[IDX_W-1:0] : left[IDX_W-1:0];
    assign win_key  = right_gt ? rdata_reg : best_key_reg;
    assign best_gt  = rdata_reg > val_reg;

    always_comb
    begin
        case (cmd.word.rd_sel)
            RA_IN:     rd_addr = req_data.index;
            RA_PARENT: rd_addr = parent;
            RA_LEFT:   rd_addr = left[IDX_W-1:0];
            RA_RIGHT:  rd_addr = right[IDX_W-1:0];
            default:   rd_addr = pos_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.word.wr_sel)
            WD_VAL:    wr_data = val_reg;
            WD_PARENT: wr_data = rdata_reg;
            WD_WIN:    wr_data = win_key;
            default:   wr_data = val_reg;
        endcase
    end

    // Heap store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (act && cmd.word.wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
        if (act && cmd.word.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (act && cmd.word.latch_in)
        begin
            op_reg  <= req_data.op;
            val_reg <= req_data.value;
            bad_reg <= ({1'b0, req_data.index} >= used);
            rd_reg  <= '0;
        end
        if (act && cmd.word.latch_rd)
        begin
            rd_reg <= rdata_reg;
        end
        if (act && cmd.word.latch_best)
        begin
            best_win_reg <= best_gt;
            best_key_reg <= best_gt ? rdata_reg : val_reg;
        end
        if (act && cmd.word.load_out)
        begin
            out_data_reg.read_value <= rd_reg;
            out_data_reg.status     <= bad_reg;
        end
        if (act && cmd.word.latch_in)
        begin
            pos_reg <= req_data.index;
        end
        else if (act)
        begin
            case (cmd.word.pos_sel)
                PS_PARENT: pos_reg <= parent;
                PS_WIN:    pos_reg <= win_idx;
                default:   pos_reg <= pos_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (act && cmd.word.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign flags.req_valid = req_valid;
    assign flags.bad       = bad_reg;
    assign flags.op        = op_reg;
    assign flags.val_gt_rd = val_reg > rdata_reg;
    assign flags.pos_root  = (pos_reg == '0);
    assign flags.left_out  = (left >= used);
    assign flags.no_win    = !right_gt && !best_win_reg;
    assign flags.out_busy  = out_valid_reg && rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    `ASSERT_RST(a_write_in_heap, clk, rst_n, ((act && cmd.word.wr_en) |-> ({1'b0, pos_reg} < used)), "store write outside used size")

endmodule

/* test/heap_update_key_checker.sv */
// ============================================================================
// heap_update_key_checker
// Watches the request, response and APB channels of the heap engine, keeps
// its own copy of the key store and heap size, predicts each response and
// compares it field by field with what the engine returns.
// ============================================================================
module heap_update_key_checker #(
    parameter logic [2:0] SIZE_ADDR = 3'd0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  huk_pkg::huk_req_t     req_data,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  huk_pkg::huk_rsp_t     rsp_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    failures,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import huk_pkg::*;

    logic signed [KEY_W-1:0] keys [DEPTH];
    logic [USED_W-1:0]       size_copy;
    huk_rsp_t                awaited_rsp_q [$];
    int                      fail_total = 0;

    assign failures = fail_total;

    function automatic void swap_keys(input int a, input int b);
        logic signed [KEY_W-1:0] t;
        t       = keys[a];
        keys[a] = keys[b];
        keys[b] = t;
    endfunction

    // Applies one request to the local store and returns the response it
    // should produce.
    function automatic huk_rsp_t apply_heap_request(input huk_req_t r);
        huk_rsp_t                rsp;
        int                      used;
        int                      pos;
        int                      up;
        int                      lft;
        int                      best;
        logic                    done;
        logic signed [KEY_W-1:0] old;
        rsp  = '0;
        used = (size_copy > DEPTH) ? DEPTH : int'(size_copy);
        pos  = int'(r.index);
        if (pos >= used)
        begin
            rsp.status = 1'b1;
        end
        else
        begin
            case (r.op)
                OP_WRITE:
                begin
                    keys[pos] = r.value;
                end
                OP_READ:
                begin
                    rsp.read_value = keys[pos];
                end
                OP_UPDATE:
                begin
                    old       = keys[pos];
                    keys[pos] = r.value;
                    done      = 1'b0;
                    if (r.value > old)
                    begin
                        while (pos > 0 && !done)
                        begin
                            up = (pos - 1) / 2;
                            if (keys[pos] > keys[up])
                            begin
                                swap_keys(pos, up);
                                pos = up;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        while (!done)
                        begin
                            lft  = 2 * pos + 1;
                            best = pos;
                            if (lft < used && keys[lft] > keys[best])
                                best = lft;
                            if (lft + 1 < used && keys[lft + 1] > keys[best])
                                best = lft + 1;
                            if (best == pos)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                swap_keys(pos, best);
                                pos = best;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        huk_rsp_t want;
        if (!rst_n)
        begin
            size_copy = '0;
            awaited_rsp_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == SIZE_ADDR)
                size_copy = pwdata[USED_W-1:0];
            // The response is checked before a request of the same edge is
            // queued, since it always belongs to an older request.
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp_q.size() == 0)
                begin
                    $error("response with no request outstanding");
                    fail_total++;
                end
                else
                begin
                    want = awaited_rsp_q.pop_front();
                    if (rsp_data.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, rsp_data.read_value);
                        fail_total++;
                    end
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, rsp_data.status);
                        fail_total++;
                    end
                end
            end
            if (req_valid && !req_stall)
                awaited_rsp_q.push_back(apply_heap_request(req_data));
            outstanding <= awaited_rsp_q.size();
        end
    end

endmodule

/* test/tb_top.sv */
// ============================================================================
// tb_top
// Stimulus and verdict for the heap update-key engine.
//
// Empty-heap requests, a full sorted fill and a directed set of sifts come
// first, then random phases: each sets a new heap size, often rebuilds a
// sorted heap, and runs a mix of updates, reads, writes and noise under one
// of four idling patterns. The checker beside the engine predicts and
// compares every response.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import huk_pkg::*;

    // Op code 3 has no meaning; the engine answers it without touching keys.
    localparam logic [1:0] OP_NONE        = 2'd3;
    localparam logic [2:0] HEAP_SIZE_ADDR = 3'd0;
    localparam int         RANDOM_ITEMS   = 350;
    localparam int         CYCLE_LIMIT    = 1000000;
    // The slowest update sifts down six levels.
    localparam int         TAIL_CYCLES    = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    huk_req_t    req_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    huk_rsp_t    rsp_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     used_entries = 0;
    int     live_items = 0;
    int     fail_count;
    int     outstanding;
    longint cycle_count = 0;

    heap_update_key dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    heap_update_key_checker #(
        .SIZE_ADDR (HEAP_SIZE_ADDR)
    ) heap_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .failures    (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The response side stalls at random, independent of anything the
    // engine does, so stalls land on every step of its program.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Guard against a hung engine or a lost response.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Selects one of the four idling patterns: none, sender only, receiver
    // only, or a lighter mix of both.
    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 73;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 73;
            end
            default:
            begin
                send_idle_pct = 22;
                stall_pct     = 22;
            end
        endcase
    endtask

    // Presents one request and returns at the edge where it is taken. Valid
    // is only lowered when a gap is rolled, so back-to-back requests keep it
    // high without a second assignment in the same step.
    task automatic send_request(input logic [1:0] op, input int idx,
                                input logic signed [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid      <= 1'b1;
        req_data.op    <= op;
        req_data.index <= idx[IDX_W-1:0];
        req_data.value <= key;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (op != OP_NONE && idx < used_entries)
            live_items++;
    endtask

    // Lowers valid and waits for every response to come back and for the
    // engine to be surely back at its idle step.
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of the heap size, a setup then an access phase; the engine
    // clamps values above its depth, and so does the local count of used entries.
    task automatic write_heap_size(input int size);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HEAP_SIZE_ADDR;
        pwdata  <= size;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        used_entries = (size > DEPTH) ? DEPTH : size;
    endtask

    // Narrow keys crowd into a few values so that equal keys and ties
    // between children come up often.
    function automatic logic signed [KEY_W-1:0] random_key(input logic narrow);
        logic signed [KEY_W-1:0] k;
        if (narrow)
            return $signed($urandom_range(8)) - 4;
        case ($urandom_range(5))
            0:       k = 32'sh7fff_ffff;
            1:       k = 32'sh8000_0000;
            2:       k = $signed($urandom_range(8)) - 4;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // Writes a non-increasing run of keys over the used entries, which is
    // always a valid max-heap, so updates afterwards sift through real
    // heap order.
    task automatic build_sorted_heap(input logic narrow);
        logic signed [KEY_W-1:0] k;
        k = narrow ? $signed($urandom_range(4)) : random_key(1'b0);
        if (k < -32'sh4000_0000)
            k = 32'sh7fff_ffff;
        for (int i = 0; i < used_entries; i++)
        begin
            send_request(OP_WRITE, i, k);
            k = k - (narrow ? $signed($urandom_range(1)) : $signed($urandom_range(1 << 20)));
        end
    endtask

    // Mostly updates, with reads to observe the heap, some writes that
    // disturb it, and a little noise: undefined ops and indexes past the
    // used size.
    task automatic run_mixed(input int count, input logic narrow);
        int         roll;
        int         idx;
        logic [1:0] op;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
                op = OP_UPDATE;
            else if (roll < 85)
                op = OP_READ;
            else if (roll < 95)
                op = OP_WRITE;
            else
                op = OP_NONE;
            if (used_entries == 0 || (used_entries < DEPTH && $urandom_range(7) == 0))
                idx = $urandom_range(DEPTH - 1, used_entries);
            else
                idx = $urandom_range(used_entries - 1);
            send_request(op, idx, random_key(narrow));
        end
    endtask

    initial
    begin
        int   phase;
        int   size;
        logic narrow;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the size still at its reset value of zero, every request is
        // flagged and the store, which holds nothing yet, is never touched.
        set_idling(0);
        send_request(OP_WRITE, 0, 32'sh7fff_ffff);
        send_request(OP_READ, 0, 0);
        send_request(OP_UPDATE, 5, 1);
        send_request(OP_NONE, 63, -1);
        wait_idle();

        // Fill the whole store in descending order, smallest key at the end.
        // Every entry is written from here on, so no later sift can compare
        // against an unwritten one.
        write_heap_size(DEPTH);
        for (int i = 0; i < DEPTH; i++)
            send_request(OP_WRITE, i,
                         (i == DEPTH - 1) ? 32'sh8000_0000 : 32'sh7fff_ffff - i * 32'sh0100_0000);
        send_request(OP_READ, 0, 0);
        send_request(OP_READ, 63, 0);
        // The last leaf gets the largest key, equal to the root: it climbs
        // all the way but stops below the root, since only a strictly larger
        // key passes its parent.
        send_request(OP_UPDATE, 63, 32'sh7fff_ffff);
        // The root gets the smallest key and sinks to a leaf.
        send_request(OP_UPDATE, 0, 32'sh8000_0000);
        send_request(OP_READ, 0, 0);
        send_request(OP_READ, 1, 0);
        send_request(OP_READ, 2, 0);
        send_request(OP_NONE, 0, 32'sh7fff_ffff);
        wait_idle();

        // One used entry: the root has no children inside the heap.
        write_heap_size(1);
        send_request(OP_UPDATE, 0, -32'sd7);
        send_request(OP_READ, 0, 0);
        send_request(OP_READ, 1, 0);
        wait_idle();

        // A size above the depth is taken as the full depth.
        write_heap_size(127);
        send_request(OP_READ, 63, 0);
        send_request(OP_UPDATE, 63, 32'sh8000_0000);
        wait_idle();

        // Two used entries: only the left child is compared on the way down.
        write_heap_size(2);
        send_request(OP_UPDATE, 1, 32'sh7fff_ffff);
        send_request(OP_UPDATE, 0, 32'sh8000_0000);
        send_request(OP_READ, 0, 0);
        send_request(OP_READ, 1, 0);
        wait_idle();

        // Random phases, each with its own size, key spread and idling.
        live_items = 0;
        phase      = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            set_idling(phase % 4);
            case ($urandom_range(9))
                0:       size = 0;
                1:       size = $urandom_range(127, DEPTH + 1);
                2:       size = 1;
                3:       size = 2;
                4, 5:    size = DEPTH;
                default: size = $urandom_range(DEPTH - 1, 3);
            endcase
            write_heap_size(size);
            narrow = ($urandom_range(2) == 0);
            if ($urandom_range(3) != 0)
                build_sorted_heap(narrow);
            run_mixed($urandom_range(60, 20), narrow);
            wait_idle();
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* heap_update_key.f */
+incdir+src
src/huk_pkg.sv
src/huk_sequencer.sv
src/huk_datapath.sv
src/heap_update_key.sv
test/heap_update_key_checker.sv
test/tb_top.sv
